### rtl/stt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants for the software timer table.
// Holds the beat structs, the status and action codes, and the controller
// state type.
// ----------------------------------------------------------------------------
package stt_pkg;

	localparam int DEF_SLOTS = 16;
	localparam int MAX_FIRED = 14;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_STOP  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_MERGED   = 3'd1,
		ST_REMOVED  = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4,
		ST_FIRED    = 3'd5
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  task_number;
		logic [15:0] event_bits;
		logic [15:0] duration;
		logic [15:0] elapsed;
	} in_beat_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  fired_task;
		logic [15:0] fired_bits;
		logic [3:0]  active_count;
		logic        last_of_run;
	} out_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_EMIT,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture input beat, start walk at head
		logic step;     // advance to next slot, current becomes prev
		logic skip;     // advance to next slot, keep prev
		logic merge;    // add duration to current slot
		logic add;      // take free slot, fill, put at head
		logic unlink;   // unlink current slot and free it
		logic wr_rem;   // write ticked remaining to current
		logic fire_inc; // count a fired result
		logic emit;     // load output register
		logic [2:0] status;
		logic with_fire; // output carries current task and bits
		logic last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] action;
		logic at_end;    // walk reached end of list or guard
		logic key_hit;   // current slot matches key
		logic free_none; // no free slot
		logic bits_zero; // current slot has zero event bits
		logic rem_zero;  // ticked remaining is zero
		logic fire_room; // fewer than the fired limit so far
		logic out_busy;  // output register still full
	} sts_t;

endpackage
`default_nettype wire

### rtl/stt_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_ram: generic single-port write, single-port read RAM.
// The read data is registered.
// ----------------------------------------------------------------------------
module stt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/stt_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_datapath: slot stores, list heads, walk pointers and output register.
// Carries out one command per cycle from the controller.
// ----------------------------------------------------------------------------
module stt_datapath #(
	parameter int TABLE_SLOTS = stt_pkg::DEF_SLOTS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stt_pkg::in_beat_t    in_beat,
	input  wire stt_pkg::cmd_t        cmd,
	output stt_pkg::sts_t             sts,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output stt_pkg::out_beat_t        out_beat
);

	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = $clog2(TABLE_SLOTS + 1);
	localparam int FW = $clog2(stt_pkg::MAX_FIRED + 1);
	localparam logic [AW-1:0] LIST_END = '0;

	// Links live in flip-flops so reset can chain the free list.
	logic [AW-1:0] link_q [TABLE_SLOTS];
	logic [AW-1:0] busy_head_q, free_head_q, cur_q, prev_q;
	logic [CW-1:0] total_q, guard_q;
	logic [FW-1:0] fired_q;
	logic          has_prev_q;
	stt_pkg::in_beat_t ib_q;
	logic [15:0] rem_calc;

	logic [7:0]  task_rd;
	logic [15:0] bits_rd, rem_rd;
	logic        we_data, we_rem;
	logic [AW-1:0] waddr;
	logic [15:0] rem_wdata;
	logic [16:0] sum;
	logic [AW-1:0] nxt;

	assign nxt = link_q[cur_q];
	assign sum = {1'b0, rem_rd} + {1'b0, ib_q.duration};

	// Ticked remaining time of the current slot, with a floor of zero.
	assign rem_calc = (rem_rd <= ib_q.elapsed) ? 16'd0 : rem_rd - ib_q.elapsed;

	// Store write selection: new entry at the free head, else current slot.
	always_comb begin
		we_data   = cmd.add;
		we_rem    = cmd.add | cmd.merge | cmd.wr_rem;
		waddr     = cmd.add ? free_head_q : cur_q;
		if (cmd.add) begin
			rem_wdata = ib_q.duration;
		end else if (cmd.merge) begin
			rem_wdata = sum[16] ? 16'hFFFF : sum[15:0];
		end else begin
			rem_wdata = rem_calc;
		end
	end

	stt_ram #(.WIDTH(8), .DEPTH(TABLE_SLOTS)) u_task (
		.clk(clk), .we(we_data), .waddr(waddr), .wdata(ib_q.task_number),
		.raddr(cur_q), .rdata(task_rd)
	);
	stt_ram #(.WIDTH(16), .DEPTH(TABLE_SLOTS)) u_bits (
		.clk(clk), .we(we_data), .waddr(waddr), .wdata(ib_q.event_bits),
		.raddr(cur_q), .rdata(bits_rd)
	);
	stt_ram #(.WIDTH(16), .DEPTH(TABLE_SLOTS)) u_rem (
		.clk(clk), .we(we_rem), .waddr(waddr), .wdata(rem_wdata),
		.raddr(cur_q), .rdata(rem_rd)
	);

	// Status toward the controller.
	always_comb begin
		sts.action    = ib_q.action;
		sts.at_end    = (cur_q == LIST_END) || (guard_q == CW'(TABLE_SLOTS));
		sts.key_hit   = (task_rd == ib_q.task_number) && (bits_rd == ib_q.event_bits);
		sts.free_none = (free_head_q == LIST_END);
		sts.bits_zero = (bits_rd == 16'd0);
		sts.rem_zero  = (rem_calc == 16'd0);
		sts.fire_room = (fired_q < FW'(stt_pkg::MAX_FIRED));
		sts.out_busy  = out_valid;
	end

	// Input beat, captured when the controller takes it.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ib_q <= in_beat;
		end
	end

	// Lists, walk pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				link_q[i] <= (i >= 2 && i + 1 < TABLE_SLOTS) ? AW'(i + 1) : LIST_END;
			end
			busy_head_q <= LIST_END;
			free_head_q <= AW'(2);
			total_q     <= '0;
			cur_q       <= LIST_END;
			prev_q      <= LIST_END;
			has_prev_q  <= 1'b0;
			guard_q     <= '0;
			fired_q     <= '0;
		end else begin
			if (cmd.load) begin
				cur_q      <= busy_head_q;
				prev_q     <= LIST_END;
				has_prev_q <= 1'b0;
				guard_q    <= '0;
				fired_q    <= '0;
			end
			if (cmd.step) begin
				prev_q     <= cur_q;
				has_prev_q <= 1'b1;
				cur_q      <= nxt;
				guard_q    <= guard_q + 1'b1;
			end
			if (cmd.skip) begin
				cur_q   <= nxt;
				guard_q <= guard_q + 1'b1;
			end
			if (cmd.add) begin
				free_head_q         <= link_q[free_head_q];
				link_q[free_head_q] <= busy_head_q;
				busy_head_q         <= free_head_q;
				total_q             <= total_q + 1'b1;
			end
			if (cmd.unlink) begin
				if (!has_prev_q) begin
					busy_head_q <= nxt;
				end else begin
					link_q[prev_q] <= nxt;
				end
				link_q[cur_q] <= free_head_q;
				free_head_q   <= cur_q;
				if (total_q != '0) begin
					total_q <= total_q - 1'b1;
				end
			end
			if (cmd.fire_inc) begin
				fired_q <= fired_q + 1'b1;
			end
		end
	end

	// Output register: one result beat held until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// The count reflects an add or unlink done in the same cycle.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_beat.status       <= cmd.status;
			out_beat.fired_task   <= cmd.with_fire ? task_rd : 8'd0;
			out_beat.fired_bits   <= cmd.with_fire ? bits_rd : 16'd0;
			out_beat.last_of_run  <= cmd.last;
			if (cmd.add) begin
				out_beat.active_count <= 4'(total_q + 1'b1);
			end else if (cmd.unlink && total_q != '0) begin
				out_beat.active_count <= 4'(total_q - 1'b1);
			end else begin
				out_beat.active_count <= 4'(total_q);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/stt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_ctrl: sequencer for start, stop and tick.
// Walks the busy list one slot at a time: a read state, then an evaluate state.
// ----------------------------------------------------------------------------
module stt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire stt_pkg::sts_t sts,
	output stt_pkg::cmd_t      cmd
);

	stt_pkg::state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands. Every emit waits for a free output register.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			stt_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stt_pkg::S_READ;
				end
			end
			stt_pkg::S_READ: begin
				if (sts.action == stt_pkg::ACT_NONE) begin
					state_d = stt_pkg::S_DONE;
				end else if (sts.at_end) begin
					state_d = stt_pkg::S_DONE;
				end else begin
					state_d = stt_pkg::S_EVAL;
				end
			end
			stt_pkg::S_EVAL: begin
				// Read data and ticked remaining are now valid for cur.
				if (sts.action == stt_pkg::ACT_TICK) begin
					cmd.wr_rem = 1'b1;
					if (sts.bits_zero) begin
						cmd.unlink = 1'b1;
						cmd.skip   = 1'b1;
						state_d    = stt_pkg::S_READ;
					end else if (sts.rem_zero && sts.fire_room) begin
						state_d = stt_pkg::S_EMIT;
					end else begin
						cmd.step = 1'b1;
						state_d  = stt_pkg::S_READ;
					end
				end else if (sts.key_hit) begin
					if (sts.out_busy) begin
						state_d = stt_pkg::S_EVAL;
					end else begin
						cmd.emit = 1'b1;
						cmd.last = 1'b1;
						if (sts.action == stt_pkg::ACT_START) begin
							cmd.merge  = 1'b1;
							cmd.status = stt_pkg::ST_MERGED;
						end else begin
							cmd.unlink = 1'b1;
							cmd.status = stt_pkg::ST_REMOVED;
						end
						state_d = stt_pkg::S_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = stt_pkg::S_READ;
				end
			end
			stt_pkg::S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit      = 1'b1;
					cmd.with_fire = 1'b1;
					cmd.status    = stt_pkg::ST_FIRED;
					cmd.unlink    = 1'b1;
					cmd.skip      = 1'b1;
					cmd.fire_inc  = 1'b1;
					state_d       = stt_pkg::S_READ;
				end
			end
			stt_pkg::S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = stt_pkg::S_IDLE;
					case (sts.action)
						stt_pkg::ACT_TICK: cmd.status = stt_pkg::ST_FIRED;
						stt_pkg::ACT_STOP: cmd.status = stt_pkg::ST_NOTFOUND;
						stt_pkg::ACT_START: begin
							if (sts.free_none) begin
								cmd.status = stt_pkg::ST_FULL;
							end else begin
								cmd.add    = 1'b1;
								cmd.status = stt_pkg::ST_ADDED;
							end
						end
						default: cmd.status = stt_pkg::ST_NOTFOUND;
					endcase
				end
			end
			default: state_d = stt_pkg::S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

### rtl/software_timer_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_unit: table of one-shot timers on a linked busy list.
// Start, stop and tick walk the busy list and report through result beats.
//
//   channel   direction  beat type            handshake
//   in        input      stt_pkg::in_beat_t   in_valid / in_stall
//   out       output     stt_pkg::out_beat_t  out_valid / out_stall
//
// Each busy slot visited passes through a read state, then an evaluate state,
// and each fired beat adds an emit state; the walk loop sets the order.
// A start or stop that finds its key ends in that slot's evaluate state.
// Start with no match and stop with no match visit every busy slot.
// Reset empties the busy list and chains the free list at once; slot data is written before any read.
// A stalled result holds the walk until the output register empties.
// ----------------------------------------------------------------------------
module software_timer_table_unit #(
	parameter int TABLE_SLOTS = stt_pkg::DEF_SLOTS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire stt_pkg::in_beat_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output stt_pkg::out_beat_t      out_data
);

	stt_pkg::cmd_t cmd;
	stt_pkg::sts_t sts;

	stt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.sts(sts), .cmd(cmd)
	);

	stt_datapath #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_beat(in_data), .cmd(cmd), .sts(sts),
		.out_valid(out_valid), .out_stall(out_stall), .out_beat(out_data)
	);

endmodule
`default_nettype wire
